FILE: hw/rtl/esc_pkg.sv
// ============================================================================
// esc_pkg: shared types and constants
// Types, constants and shift functions used by the modules of the sensor compensation block.
// ============================================================================
package esc_pkg;

    // Width of the pressure divider operands.
    localparam int DIV_W = 64;

    // Upper clamp of humidity before the final shift.
    localparam logic [31:0] HUM_MAX = 32'd419430400;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_TEMP       = 3'd0,
        REG_PRESS_A    = 3'd1,
        REG_PRESS_B    = 3'd2,
        REG_PRESS_NINE = 3'd3,
        REG_HUM_A      = 3'd4,
        REG_HUM_B      = 3'd5
    } reg_index_t;

    // Calibration words as held in the configuration registers.
    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] press_a;
        logic [63:0] press_b;
        logic [15:0] press_nine;
        logic [39:0] hum_a;
        logic [31:0] hum_b;
    } coeff_t;

    // One sample after the front end has prepared the temperature terms.
    typedef struct packed {
        logic [31:0] temp_a;
        logic [31:0] temp_d;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } item_t;

    // Side data that rides along with a division.
    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        neg;
        logic        zero;
    } div_tag_t;

    // Arithmetic right shifts at the two wrap widths.
    function automatic logic [31:0] sra32(logic [31:0] x, int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sra64(logic [63:0] x, int unsigned n);
        return 64'($signed(x) >>> n);
    endfunction

endpackage

FILE: hw/rtl/esc_front.sv
// ============================================================================
// esc_front: sample intake
// Accepts one raw sample, forms the first temperature terms and hands the
// item to the queue.
// ============================================================================
module esc_front
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [19:0] raw_temp,
    input  logic [19:0] raw_press,
    input  logic [15:0] raw_hum,
    input  logic [15:0] t1,
    output logic        push,
    output item_t       push_data,
    input  logic        full
);

    logic  valid_reg;
    logic  take;
    item_t item_reg;
    item_t item_next;

    // The held item moves on whenever the queue has room.
    assign push     = valid_reg && !full;
    assign in_stall = valid_reg && full;
    assign take     = in_valid && !in_stall;

    // Temperature offsets against T1.
    always_comb
    begin
        item_next.temp_a    = {15'b0, raw_temp[19:3]} - {15'b0, t1, 1'b0};
        item_next.temp_d    = {16'b0, raw_temp[19:4]} - {16'b0, t1};
        item_next.raw_press = raw_press;
        item_next.raw_hum   = raw_hum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take || push)
        begin
            valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign push_data = item_reg;

endmodule

FILE: hw/rtl/esc_fifo.sv
// ============================================================================
// esc_fifo: item queue
// Short first-in first-out queue between the front end and the datapath.
// ============================================================================
module esc_fifo
    import esc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_data,
    output logic  full,
    input  logic  pop,
    output item_t pop_data,
    output logic  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/esc_div.sv
// ============================================================================
// esc_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, with side data carried
// along each stage.
// ============================================================================
module esc_div
    import esc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DIV_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    input  div_tag_t         tag_in,
    output logic             out_valid,
    output logic [DIV_W-1:0] quot,
    output div_tag_t         tag_out
);

    logic [DIV_W:0]   valid_reg;
    logic [DIV_W-1:0] num_reg [DIV_W+1];
    logic [DIV_W-1:0] rem_reg [DIV_W+1];
    logic [DIV_W-1:0] den_reg [DIV_W+1];
    div_tag_t         tag_reg [DIV_W+1];

    // Valid bits shift with the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DIV_W-1:0], in_valid};
        end
    end

    // Input stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= num;
            rem_reg[0] <= '0;
            den_reg[0] <= den;
            tag_reg[0] <= tag_in;
        end
    end

    // Each stage brings in one dividend bit and decides one quotient bit.
    for (genvar i = 1; i <= DIV_W; i++)
    begin : g_stage
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        logic           ge;

        assign trial = {rem_reg[i-1], num_reg[i-1][DIV_W-1]};
        assign diff  = trial - {1'b0, den_reg[i-1]};
        assign ge    = (trial >= {1'b0, den_reg[i-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                num_reg[i] <= {num_reg[i-1][DIV_W-2:0], ge};
                den_reg[i] <= den_reg[i-1];
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[DIV_W];
    assign quot      = num_reg[DIV_W];
    assign tag_out   = tag_reg[DIV_W];

endmodule

FILE: hw/rtl/esc_back.sv
// ============================================================================
// esc_back: compensation datapath
// Pipelined temperature, pressure and humidity polynomials with the
// pressure division, ending in the output register.
// ============================================================================
module esc_back
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  coeff_t      coeff,
    input  logic        empty,
    input  item_t       pop_data,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] temp_centi,
    output logic [31:0] press_q24_8,
    output logic [16:0] hum_q22_10
);

    logic en;
    logic out_valid_reg;
    logic [8:0] vb_reg;
    logic [4:0] vc_reg;

    // Coefficient fields.
    logic [31:0] t2_32, t3_32;
    logic signed [15:0] p2s, p3s, p5s, p6s, p8s, p9s;
    logic [15:0] p1;
    logic [63:0] p4_64, p7_64;
    logic [31:0] h1_32, h2_32, h3_32, h4_32, h5_32, h6_32;

    assign t2_32 = {{16{coeff.temp[31]}}, coeff.temp[31:16]};
    assign t3_32 = {{16{coeff.temp[47]}}, coeff.temp[47:32]};
    assign p1    = coeff.press_a[15:0];
    assign p2s   = coeff.press_a[31:16];
    assign p3s   = coeff.press_a[47:32];
    assign p4_64 = {{48{coeff.press_a[63]}}, coeff.press_a[63:48]};
    assign p5s   = coeff.press_b[15:0];
    assign p6s   = coeff.press_b[31:16];
    assign p7_64 = {{48{coeff.press_b[47]}}, coeff.press_b[47:32]};
    assign p8s   = coeff.press_b[63:48];
    assign p9s   = coeff.press_nine;
    assign h1_32 = {24'b0, coeff.hum_a[7:0]};
    assign h2_32 = {{16{coeff.hum_a[23]}}, coeff.hum_a[23:8]};
    assign h3_32 = {24'b0, coeff.hum_a[31:24]};
    assign h6_32 = {{24{coeff.hum_a[39]}}, coeff.hum_a[39:32]};
    assign h4_32 = {{16{coeff.hum_b[15]}}, coeff.hum_b[15:0]};
    assign h5_32 = {{16{coeff.hum_b[31]}}, coeff.hum_b[31:16]};

    // The whole pipeline holds while a finished result waits.
    assign en  = !(out_valid_reg && out_stall);
    assign pop = en && !empty;

    // Stage registers.
    logic [31:0] m1_reg, dd_reg, v1t_reg, m2_reg, fine_reg, temp4_reg, hv_reg;
    logic [19:0] rp1_reg, rp2_reg, rp3_reg, rp4_reg;
    logic [15:0] rh1_reg, rh2_reg, rh3_reg, rh4_reg;
    logic [63:0] pv1_reg;
    logic [31:0] temp5_reg, temp6_reg, temp7_reg, temp8_reg, temp9_reg;
    logic [63:0] sq_reg, q5_reg, q2_reg, padc5_reg;
    logic [31:0] x0_reg, y0a_reg, y0b_reg;
    logic [63:0] a6_reg, a3_reg, v2p_reg, v1b_reg, padc6_reg;
    logic [31:0] x6_reg, y1_reg;
    logic [63:0] num0_reg, v1c_reg;
    logic [31:0] x7_reg, y3_reg;
    logic [63:0] m_reg, num8_reg;
    logic [31:0] hvv8_reg;
    logic [63:0] den9_reg, num9_reg;
    logic [31:0] hvv9_reg, ss9_reg;

    // Combinational terms per stage.
    logic [31:0] sdd, fine5, x0_next, y0a_next, y0b_next, y1_next, y2, y3_next;
    logic [31:0] s9, w10, hv2;
    logic signed [32:0] v33;
    logic signed [65:0] sqf;
    logic signed [48:0] q5f, q2f;
    logic signed [79:0] a6f, a3f;
    logic [63:0] v2_7, v1c_next, base8, num8_next;
    logic [79:0] mf;
    logic [16:0] hum10;
    logic [63:0] an10, ad10;
    div_tag_t    tag10;

    assign sdd   = sra32(dd_reg, 12);
    assign fine5 = fine_reg * 32'd5 + 32'd128;

    // Pressure polynomial terms.
    assign v33  = pv1_reg[32:0];
    assign sqf  = v33 * v33;
    assign q5f  = v33 * p5s;
    assign q2f  = v33 * p2s;
    assign a6f  = $signed(sq_reg) * p6s;
    assign a3f  = $signed(sq_reg) * p3s;
    assign v2_7 = a6_reg + v2p_reg;
    assign v1c_next  = sra64(a3_reg, 8) + v1b_reg;
    assign base8     = 64'h0000_8000_0000_0000 + v1c_reg;
    assign mf        = base8 * p1;
    assign num8_next = num0_reg * 64'd3125;

    // Humidity polynomial terms.
    assign x0_next  = {2'b0, rh4_reg, 14'b0} - {h4_32[11:0], 20'b0}
                      - h5_32 * hv_reg + 32'd16384;
    assign y0a_next = hv_reg * h6_32;
    assign y0b_next = hv_reg * h3_32;
    assign y1_next  = sra32(y0a_reg, 10) * (sra32(y0b_reg, 11) + 32'd32768);
    assign y2       = sra32(y1_reg, 10);
    assign y3_next  = sra32((y2 + 32'd2097152) * h2_32 + 32'd8192, 14);
    assign s9       = sra32(hvv8_reg, 15);
    assign w10      = sra32(sra32(ss9_reg, 7) * h1_32, 4);
    assign hv2      = hvv9_reg - w10;

    // Humidity clamp and final shift.
    always_comb
    begin
        priority if (hv2[31])
        begin
            hum10 = '0;
        end
        else if (hv2 > HUM_MAX)
        begin
            hum10 = HUM_MAX[28:12];
        end
        else
        begin
            hum10 = hv2[28:12];
        end
    end

    // Sign handling around the unsigned divider.
    assign an10       = num9_reg[63] ? 64'd0 - num9_reg : num9_reg;
    assign ad10       = den9_reg[63] ? 64'd0 - den9_reg : den9_reg;
    assign tag10.temp = temp9_reg;
    assign tag10.hum  = hum10;
    assign tag10.neg  = num9_reg[63] ^ den9_reg[63];
    assign tag10.zero = (den9_reg == '0);

    // Valid bits of the stages before and after the divider.
    logic     div_valid;
    logic [63:0] quot;
    div_tag_t div_tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg        <= '0;
            vc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vb_reg        <= {vb_reg[7:0], pop};
            vc_reg        <= {vc_reg[3:0], div_valid};
            out_valid_reg <= vc_reg[4];
        end
    end

    // Front half of the datapath: temperature, then pressure and humidity.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg    <= pop_data.temp_a * t2_32;
            dd_reg    <= pop_data.temp_d * pop_data.temp_d;
            rp1_reg   <= pop_data.raw_press;
            rh1_reg   <= pop_data.raw_hum;

            v1t_reg   <= sra32(m1_reg, 11);
            m2_reg    <= sdd * t3_32;
            rp2_reg   <= rp1_reg;
            rh2_reg   <= rh1_reg;

            fine_reg  <= v1t_reg + sra32(m2_reg, 14);
            rp3_reg   <= rp2_reg;
            rh3_reg   <= rh2_reg;

            temp4_reg <= sra32(fine5, 8);
            pv1_reg   <= {{32{fine_reg[31]}}, fine_reg} - 64'd128000;
            hv_reg    <= fine_reg - 32'd76800;
            rp4_reg   <= rp3_reg;
            rh4_reg   <= rh3_reg;

            temp5_reg <= temp4_reg;
            sq_reg    <= sqf[63:0];
            q5_reg    <= {{15{q5f[48]}}, q5f};
            q2_reg    <= {{15{q2f[48]}}, q2f};
            padc5_reg <= 64'd1048576 - {44'b0, rp4_reg};
            x0_reg    <= x0_next;
            y0a_reg   <= y0a_next;
            y0b_reg   <= y0b_next;

            temp6_reg <= temp5_reg;
            a6_reg    <= a6f[63:0];
            a3_reg    <= a3f[63:0];
            v2p_reg   <= (q5_reg << 17) + (p4_64 << 35);
            v1b_reg   <= q2_reg << 12;
            padc6_reg <= padc5_reg;
            x6_reg    <= sra32(x0_reg, 15);
            y1_reg    <= y1_next;

            temp7_reg <= temp6_reg;
            num0_reg  <= (padc6_reg << 31) - v2_7;
            v1c_reg   <= v1c_next;
            x7_reg    <= x6_reg;
            y3_reg    <= y3_next;

            temp8_reg <= temp7_reg;
            m_reg     <= mf[63:0];
            num8_reg  <= num8_next;
            hvv8_reg  <= x7_reg * y3_reg;

            temp9_reg <= temp8_reg;
            den9_reg  <= sra64(m_reg, 33);
            num9_reg  <= num8_reg;
            hvv9_reg  <= hvv8_reg;
            ss9_reg   <= s9 * s9;
        end
    end

    esc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vb_reg[8]),
        .num       (an10),
        .den       (ad10),
        .tag_in    (tag10),
        .out_valid (div_valid),
        .quot      (quot),
        .tag_out   (div_tag)
    );

    // Back half: pressure correction terms after the division, then the output registers.
    logic [63:0] pc0_reg, pc1_reg, pc2_reg, pc3_reg;
    logic [63:0] h1c_reg, t1c_reg, u1c_reg;
    logic [63:0] pp0_reg, v2c2_reg, th_reg, v2c3_reg, s4_reg;
    logic [31:0] pp1_reg, pp2_reg;
    div_tag_t    tag0_reg, tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [63:0] hc1;
    logic signed [79:0] tf, uf;
    logic [63:0] res;
    logic [31:0] temp_out_reg, press_out_reg;
    logic [16:0] hum_out_reg;

    assign hc1 = sra64(pc0_reg, 13);
    assign tf  = $signed(hc1) * p9s;
    assign uf  = $signed(pc0_reg) * p8s;
    assign res = sra64(s4_reg, 8) + (p7_64 << 4);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pc0_reg  <= div_tag.neg ? 64'd0 - quot : quot;
            tag0_reg <= div_tag;

            pc1_reg  <= pc0_reg;
            h1c_reg  <= hc1;
            t1c_reg  <= tf[63:0];
            u1c_reg  <= uf[63:0];
            tag1_reg <= tag0_reg;

            pc2_reg  <= pc1_reg;
            pp0_reg  <= t1c_reg[31:0] * h1c_reg[31:0];
            pp1_reg  <= t1c_reg[31:0] * h1c_reg[63:32];
            pp2_reg  <= t1c_reg[63:32] * h1c_reg[31:0];
            v2c2_reg <= sra64(u1c_reg, 19);
            tag2_reg <= tag1_reg;

            pc3_reg  <= pc2_reg;
            th_reg   <= pp0_reg + {pp1_reg + pp2_reg, 32'b0};
            v2c3_reg <= v2c2_reg;
            tag3_reg <= tag2_reg;

            s4_reg   <= pc3_reg + sra64(th_reg, 25) + v2c3_reg;
            tag4_reg <= tag3_reg;

            temp_out_reg  <= tag4_reg.temp;
            hum_out_reg   <= tag4_reg.hum;
            press_out_reg <= tag4_reg.zero ? 32'd0 : res[31:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign temp_centi  = temp_out_reg;
    assign press_q24_8 = press_out_reg;
    assign hum_q22_10  = hum_out_reg;

endmodule

FILE: hw/rtl/env_sensor_compensation.sv
// ============================================================================
// env_sensor_compensation: environmental sensor compensation top level
// Throughput: one sample per cycle while the output is not stalled; the
// datapath and the divider are fully pipelined and the queue between
// front and back absorbs stalls.
// Reset: asynchronous active-low reset clears all valid bits, the queue and
// the calibration registers to zero.
// ============================================================================
module env_sensor_compensation
    import esc_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [19:0] raw_temp,
    input  logic [19:0] raw_press,
    input  logic [15:0] raw_hum,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] temp_centi,
    output logic [31:0] press_q24_8,
    output logic [16:0] hum_q22_10
);

    coeff_t coeff_reg;
    logic   push, full, pop, empty;
    item_t  push_data, pop_data;

    // Calibration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_TEMP:       coeff_reg.temp       <= cfg_data[47:0];
                REG_PRESS_A:    coeff_reg.press_a    <= cfg_data;
                REG_PRESS_B:    coeff_reg.press_b    <= cfg_data;
                REG_PRESS_NINE: coeff_reg.press_nine <= cfg_data[15:0];
                REG_HUM_A:      coeff_reg.hum_a      <= cfg_data[39:0];
                REG_HUM_B:      coeff_reg.hum_b      <= cfg_data[31:0];
                default:        coeff_reg            <= coeff_reg;
            endcase
        end
    end

    esc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .raw_temp  (raw_temp),
        .raw_press (raw_press),
        .raw_hum   (raw_hum),
        .t1        (coeff_reg.temp[15:0]),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    esc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    esc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .coeff       (coeff_reg),
        .empty       (empty),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .temp_centi  (temp_centi),
        .press_q24_8 (press_q24_8),
        .hum_q22_10  (hum_q22_10)
    );

endmodule

FILE: tb/sv/env_sensor_compensation_tb.sv
// ============================================================================
// env_sensor_compensation_tb: self-checking testbench of the compensation block
// Drives raw samples through the valid/stall handshake, predicts each
// calibrated result with an independent integer model of the compensation
// polynomials and compares every output transfer field by field. The
// calibration registers are rewritten between phases, extremes included.
// ============================================================================
module env_sensor_compensation_tb
    import esc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic [16:0] hum;
    } reading_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] temp_centi;
    logic [31:0] press_q24_8;
    logic [16:0] hum_q22_10;

    // Local copy of the calibration registers.
    logic [47:0] cal_temp;
    logic [63:0] cal_press_a;
    logic [63:0] cal_press_b;
    logic [15:0] cal_press_nine;
    logic [39:0] cal_hum_a;
    logic [31:0] cal_hum_b;

    reading_t    pending_readings[$];
    bit          failed;
    bit          in_idle_on;
    bit          out_idle_on;
    int          hold_left;
    int unsigned cycle_count;

    env_sensor_compensation i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .raw_temp(raw_temp), .raw_press(raw_press), .raw_hum(raw_hum),
        .out_valid(out_valid), .out_stall(out_stall),
        .temp_centi(temp_centi), .press_q24_8(press_q24_8), .hum_q22_10(hum_q22_10)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Compensation of one sample: temperature, then pressure and humidity.
    function automatic reading_t compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
        reading_t r;
        logic signed [31:0] t1, t2, t3, va, d, vb, fine;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] w1, w2, pp, hh, mn, md, q;
        logic signed [31:0] h1, h2, h3, h4, h5, h6, v, x, y, s;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        va = $signed((({12'd0, rt} >> 3) - (t1 << 1)) * t2) >>> 11;
        d  = ({12'd0, rt} >> 4) - t1;
        vb = (((d * d) >>> 12) * t3) >>> 14;
        fine = va + vb;
        r.temp = (fine * 5 + 128) >>> 8;

        p1 = {48'd0, cal_press_a[15:0]};
        p2 = {{48{cal_press_a[31]}}, cal_press_a[31:16]};
        p3 = {{48{cal_press_a[47]}}, cal_press_a[47:32]};
        p4 = {{48{cal_press_a[63]}}, cal_press_a[63:48]};
        p5 = {{48{cal_press_b[15]}}, cal_press_b[15:0]};
        p6 = {{48{cal_press_b[31]}}, cal_press_b[31:16]};
        p7 = {{48{cal_press_b[47]}}, cal_press_b[47:32]};
        p8 = {{48{cal_press_b[63]}}, cal_press_b[63:48]};
        p9 = {{48{cal_press_nine[15]}}, cal_press_nine};
        w1 = 64'(fine) - 64'sd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) <<< 17);
        w2 = w2 + (p4 <<< 35);
        w1 = ((w1 * w1 * p3) >>> 8) + ((w1 * p2) <<< 12);
        w1 = (((64'sd1 <<< 47) + w1) * p1) >>> 33;
        if (w1 == 0)
        begin
            r.press = 32'd0;
        end
        else
        begin
            pp = 64'sd1048576 - {44'd0, rp};
            pp = ((pp <<< 31) - w2) * 64'sd3125;
            // Truncating division on magnitudes; the wrap of the most
            // negative dividend falls out of the unsigned arithmetic.
            mn = pp[63] ? -pp : pp;
            md = w1[63] ? -w1 : w1;
            q  = $signed(64'($unsigned(mn) / $unsigned(md)));
            pp = (pp[63] != w1[63]) ? -q : q;
            hh = pp >>> 13;
            w1 = (p9 * hh * hh) >>> 25;
            w2 = (p8 * pp) >>> 19;
            pp = ((pp + w1 + w2) >>> 8) + (p7 <<< 4);
            r.press = pp[31:0];
        end

        h1 = {24'd0, cal_hum_a[7:0]};
        h2 = {{16{cal_hum_a[23]}}, cal_hum_a[23:8]};
        h3 = {24'd0, cal_hum_a[31:24]};
        h6 = {{24{cal_hum_a[39]}}, cal_hum_a[39:32]};
        h4 = {{16{cal_hum_b[15]}}, cal_hum_b[15:0]};
        h5 = {{16{cal_hum_b[31]}}, cal_hum_b[31:16]};
        v = fine - 32'sd76800;
        x = $signed(({16'd0, rh} << 14) - (h4 << 20) - h5 * v + 32'sd16384) >>> 15;
        y = (((v * h6) >>> 10) * (((v * h3) >>> 11) + 32'sd32768)) >>> 10;
        y = ((y + 32'sd2097152) * h2 + 32'sd8192) >>> 14;
        v = x * y;
        s = v >>> 15;
        v = v - ((((s * s) >>> 7) * h1) >>> 4);
        if (v < 0)
            v = 0;
        if (v > $signed(HUM_MAX))
            v = $signed(HUM_MAX);
        r.hum = 17'(v >>> 12);
        return r;
    endfunction

    // Sends one calibration word; the block must be idle.
    task automatic write_coeff(reg_index_t idx, logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        unique case (idx)
            REG_TEMP:       cal_temp       = value[47:0];
            REG_PRESS_A:    cal_press_a    = value;
            REG_PRESS_B:    cal_press_b    = value;
            REG_PRESS_NINE: cal_press_nine = value[15:0];
            REG_HUM_A:      cal_hum_a      = value[39:0];
            REG_HUM_B:      cal_hum_b      = value[31:0];
            default: ;
        endcase
    endtask

    task automatic load_coeffs(logic [47:0] t, logic [63:0] pa, logic [63:0] pb,
                               logic [15:0] p9, logic [39:0] ha, logic [31:0] hb);
        write_coeff(REG_TEMP, {16'd0, t});
        write_coeff(REG_PRESS_A, pa);
        write_coeff(REG_PRESS_B, pb);
        write_coeff(REG_PRESS_NINE, {48'd0, p9});
        write_coeff(REG_HUM_A, {24'd0, ha});
        write_coeff(REG_HUM_B, {32'd0, hb});
    endtask

    // Typical calibration of the sensor family.
    task automatic load_typical();
        load_coeffs({16'd50, 16'd26435, 16'd27504},
                    {16'd2855, 16'd3024, 16'hD0D5, 16'd36477},
                    {16'd15500, 16'hFFF9, 16'hFF79, 16'd140},
                    16'd6000,
                    {8'sd30, 8'd0, 16'd362, 8'd75},
                    {16'd50, 16'd290});
    endtask

    // Random calibration words over the full field ranges.
    task automatic load_random();
        load_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                    16'($urandom), 40'({$urandom, $urandom}), $urandom);
    endtask

    // Offers one sample and holds it until the transfer. The valid stays
    // high afterwards; the next sample or the drain takes it down.
    task automatic send_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
        while (in_idle_on && ($urandom_range(99) < 6))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        raw_temp  <= rt;
        raw_press <= rp;
        raw_hum   <= rh;
        pending_readings.push_back(compensate(rt, rp, rh));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_sample(20'($urandom), 20'($urandom), 16'($urandom));
    endtask

    // Waits for every expected result, then lets the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_coeffs();
        send_sample(20'd0, 20'd0, 16'd0);
        send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        drain();
    endtask

    task automatic test_typical();
        load_typical();
        send_sample(20'd519888, 20'd415148, 16'd28000);
        send_sample(20'd0, 20'd0, 16'd0);
        send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_sample(20'd0, 20'hFFFFF, 16'hFFFF);
        send_sample(20'hFFFFF, 20'd0, 16'd0);
        send_sample(20'h55555, 20'hAAAAA, 16'h5555);
        send_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
        send_sample(20'd524288, 20'd524288, 16'd32768);
        drain();
    endtask

    // Zero pressure divisor: P1 of zero, other fields still computed.
    task automatic test_zero_divisor();
        write_coeff(REG_PRESS_A, 64'h8000_7FFF_8000_0000);
        send_sample(20'd519888, 20'd415148, 16'd28000);
        send_sample(20'hFFFFF, 20'd1, 16'hFFFF);
        drain();
    endtask

    // Extreme calibration words drive overflow and the humidity clamps.
    task automatic test_extreme_coeffs();
        load_coeffs('1, '1, '1, 16'h8000, '1, '1);
        send_sample(20'hFFFFF, 20'd0, 16'hFFFF);
        send_sample(20'd0, 20'hFFFFF, 16'd0);
        drain();
        load_coeffs({16'h8000, 16'h7FFF, 16'hFFFF},
                    {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                    {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
                    16'h7FFF, {8'h7F, 8'hFF, 16'h7FFF, 8'hFF}, {16'h7FFF, 16'h8000});
        send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_sample(20'd0, 20'd0, 16'd0);
        send_sample(20'd300000, 20'd1000, 16'd40000);
        drain();
    endtask

    task automatic test_random_typical();
        load_typical();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        send_random(150);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        send_random(450);
        drain();
    endtask

    task automatic test_random_coeffs();
        for (int k = 0; k < 8; k++)
        begin
            load_random();
            send_random(80);
            drain();
        end
    endtask

    // Receiver holds off while samples keep coming so the input stalls.
    task automatic test_backpressure();
        load_typical();
        hold_left = 200;
        send_random(150);
        drain();
    endtask

    // Output stall: random idling, or a counted hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= out_idle_on && ($urandom_range(99) < 6);
        end
    end

    // Compares each output transfer with the oldest expected reading.
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                $display("%0t: unexpected result temp=%0d press=%0d hum=%0d",
                         $time, $signed(temp_centi), press_q24_8, hum_q22_10);
                failed = 1'b1;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (temp_centi !== want.temp)
                begin
                    $display("%0t: temp_centi expected %0d actual %0d",
                             $time, $signed(want.temp), $signed(temp_centi));
                    failed = 1'b1;
                end
                if (press_q24_8 !== want.press)
                begin
                    $display("%0t: press_q24_8 expected %0d actual %0d",
                             $time, want.press, press_q24_8);
                    failed = 1'b1;
                end
                if (hum_q22_10 !== want.hum)
                begin
                    $display("%0t: hum_q22_10 expected %0d actual %0d",
                             $time, want.hum, hum_q22_10);
                    failed = 1'b1;
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        failed      = 1'b0;
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        hold_left   = 0;
        cycle_count = 0;
        cal_temp = '0; cal_press_a = '0; cal_press_b = '0;
        cal_press_nine = '0; cal_hum_a = '0; cal_hum_b = '0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        raw_temp  = '0;
        raw_press = '0;
        raw_hum   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_coeffs();
        test_typical();
        test_zero_divisor();
        test_extreme_coeffs();
        test_random_typical();
        test_random_coeffs();
        test_backpressure();

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: env_sensor_compensation.f
hw/rtl/esc_pkg.sv
hw/rtl/esc_front.sv
hw/rtl/esc_fifo.sv
hw/rtl/esc_div.sv
hw/rtl/esc_back.sv
hw/rtl/env_sensor_compensation.sv
tb/sv/env_sensor_compensation_tb.sv
